// ===== design/pfla_pkg.sv =====
// Shared constants for the LIFO free-page allocator: defaults for sizing,
// command, status and CSR index codes. No dependencies.
package pfla_pkg;

   localparam int PFLA_MAX_PAGES  = 32768;
   localparam int PFLA_PAGE_BYTES = 4096;
   localparam int PFLA_ADDR_BITS  = 34;

   localparam int FREE_W   = 16;
   localparam int CMD_W    = 2;
   localparam int STATUS_W = 2;
   localparam int CSR_IDX_W = 1;

   localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_INIT  = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_POOL_BASE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_POOL_TOP  = 1'b1;

endpackage

// ===== design/pfla_stack_mem.sv =====
// Freed-page stack storage: single synchronous RAM, one write and one read
// per cycle, registered read data. Uses no package items.
module pfla_stack_mem #(
   parameter int DEPTH  = 32768,
   parameter int IDX_W  = 15,
   parameter int DATA_W = 22
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [IDX_W-1:0]  wr_idx,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [IDX_W-1:0]  rd_idx,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_idx];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/pfla_pool_calc.sv =====
// Pool geometry for the init command: first whole page at or above the
// base, and page count clamped to the store size. Depends on pfla_pkg.
module pfla_pool_calc import pfla_pkg::*; #(
   parameter int MAX_PAGES  = PFLA_MAX_PAGES,
   parameter int PAGE_BYTES = PFLA_PAGE_BYTES,
   parameter int ADDR_BITS  = PFLA_ADDR_BITS
) (
   input  logic [ADDR_BITS-1:0]                               pool_base,
   input  logic [ADDR_BITS-1:0]                               pool_top,
   output logic [ADDR_BITS-$clog2(PAGE_BYTES)-1:0]            first_page,
   output logic [$clog2(MAX_PAGES+1)-1:0]                     page_count,
   output logic                                               clamped
);

   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int PNW        = ADDR_BITS - PAGE_SHIFT;
   localparam int CNT_W      = $clog2(MAX_PAGES + 1);
   localparam int SPAN_W     = (PNW + 1 > CNT_W) ? PNW + 1 : CNT_W;

   logic [ADDR_BITS:0]  base_up;
   logic [PNW:0]        first_w;
   logic [PNW:0]        last_w;
   logic [PNW:0]        span;
   logic [SPAN_W-1:0]   span_x;

   always_comb begin
      // round the base up to a page boundary
      base_up = {1'b0, pool_base} + (ADDR_BITS + 1)'(PAGE_BYTES - 1);
      first_w = base_up[ADDR_BITS:PAGE_SHIFT];
      last_w  = {1'b0, pool_top[ADDR_BITS-1:PAGE_SHIFT]};
      if (last_w > first_w) begin
         span = last_w - first_w;
      end else begin
         span = '0;
      end
      span_x     = SPAN_W'(span);
      clamped    = span_x > SPAN_W'(MAX_PAGES);
      page_count = clamped ? CNT_W'(MAX_PAGES) : CNT_W'(span_x);
      first_page = first_w[PNW-1:0];
   end

endmodule

// ===== design/page_free_list_allocator.sv =====
// LIFO free-page allocator. The result strobe is registered and rises in the cycle after an accepted start.
// Throughput: one command per cycle; a pop issues its stack RAM read at the
// accept edge and the registered read data drives the result directly.
// Reset (synchronous): counts, pool registers and strobe cleared; stack RAM
// is not cleared. busy is high only while reset is held; no result stall.
module page_free_list_allocator import pfla_pkg::*; #(
   parameter int MAX_PAGES  = PFLA_MAX_PAGES,
   parameter int PAGE_BYTES = PFLA_PAGE_BYTES,
   parameter int ADDR_BITS  = PFLA_ADDR_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [CMD_W-1:0]      req_command,
   input  logic [ADDR_BITS-1:0]  req_page_address,
   output logic                  rsp_valid,
   output logic [ADDR_BITS-1:0]  rsp_granted_address,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [FREE_W-1:0]     rsp_free_pages,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [ADDR_BITS-1:0]  csr_write_data
);

   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int PNW        = ADDR_BITS - PAGE_SHIFT;
   localparam int CNT_W      = $clog2(MAX_PAGES + 1);
   localparam int IDX_W      = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;

   logic [ADDR_BITS-1:0] pool_base_ff, pool_base_in;
   logic [ADDR_BITS-1:0] pool_top_ff, pool_top_in;
   logic [CNT_W-1:0]     freed_count_ff, freed_count_in;
   logic [CNT_W-1:0]     untouched_count_ff, untouched_count_in;
   logic [PNW-1:0]       untouched_base_ff, untouched_base_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 pop_ff, pop_in;
   logic [ADDR_BITS-1:0] granted_ff, granted_in;
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic [FREE_W-1:0]    free_pages_ff, free_pages_in;

   logic                 accept;
   logic [CNT_W:0]       total;
   logic [CNT_W-1:0]     freed_dec;
   logic [PNW-1:0]       grant_page;
   logic                 bad_free;
   logic                 mem_wr_en;
   logic                 mem_rd_en;
   logic [PNW-1:0]       mem_rd_data;
   logic [PNW-1:0]       init_first;
   logic [CNT_W-1:0]     init_count;
   logic                 init_clamped;

   assign busy   = reset;
   assign accept = start & ~busy;
   assign total  = {1'b0, freed_count_ff} + {1'b0, untouched_count_ff};
   assign freed_dec = freed_count_ff - 1'b1;

   pfla_pool_calc #(
      .MAX_PAGES (MAX_PAGES),
      .PAGE_BYTES(PAGE_BYTES),
      .ADDR_BITS (ADDR_BITS)
   ) u_pool_calc (
      .pool_base (pool_base_ff),
      .pool_top  (pool_top_ff),
      .first_page(init_first),
      .page_count(init_count),
      .clamped   (init_clamped)
   );

   // a later pop of the same slot is accepted in a later cycle than its push,
   // so the RAM read always sees the completed write
   pfla_stack_mem #(
      .DEPTH (MAX_PAGES),
      .IDX_W (IDX_W),
      .DATA_W(PNW)
   ) u_stack_mem (
      .clock  (clock),
      .wr_en  (mem_wr_en),
      .wr_idx (freed_count_ff[IDX_W-1:0]),
      .wr_data(req_page_address[ADDR_BITS-1:PAGE_SHIFT]),
      .rd_en  (mem_rd_en),
      .rd_idx (freed_dec[IDX_W-1:0]),
      .rd_data(mem_rd_data)
   );

   always_comb begin
      pool_base_in = pool_base_ff;
      pool_top_in  = pool_top_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_POOL_BASE: pool_base_in = csr_write_data;
            CSR_POOL_TOP:  pool_top_in  = csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      bad_free = (req_page_address[PAGE_SHIFT-1:0] != '0) ||
                 (req_page_address < pool_base_ff) ||
                 (req_page_address >= pool_top_ff);

      freed_count_in     = freed_count_ff;
      untouched_count_in = untouched_count_ff;
      untouched_base_in  = untouched_base_ff;
      rsp_valid_in       = accept;
      pop_in             = 1'b0;
      granted_in         = '0;
      status_in          = ST_OK;
      mem_wr_en          = 1'b0;
      mem_rd_en          = 1'b0;
      grant_page         = '0;

      if (accept) begin
         case (req_command)
            CMD_ALLOC: begin
               if (freed_count_ff != '0) begin
                  freed_count_in = freed_dec;
                  mem_rd_en      = 1'b1;
                  pop_in         = 1'b1;
               end else if (untouched_count_ff != '0) begin
                  untouched_count_in = untouched_count_ff - 1'b1;
                  // highest untouched page goes first
                  grant_page = untouched_base_ff + PNW'(untouched_count_in);
                  granted_in = ADDR_BITS'(grant_page) << PAGE_SHIFT;
               end else begin
                  status_in = ST_EMPTY;
               end
            end
            CMD_FREE: begin
               if (bad_free) begin
                  status_in = ST_BAD;
               end else if (total >= (CNT_W + 1)'(MAX_PAGES)) begin
                  status_in = ST_FULL;
               end else begin
                  mem_wr_en      = 1'b1;
                  freed_count_in = freed_count_ff + 1'b1;
               end
            end
            CMD_INIT: begin
               freed_count_in     = '0;
               untouched_count_in = init_count;
               untouched_base_in  = init_first;
               if (init_clamped) begin
                  status_in = ST_FULL;
               end
            end
            default: ;
         endcase
      end

      free_pages_in = FREE_W'({1'b0, freed_count_in} + {1'b0, untouched_count_in});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_base_ff       <= '0;
         pool_top_ff        <= '0;
         freed_count_ff     <= '0;
         untouched_count_ff <= '0;
         untouched_base_ff  <= '0;
         rsp_valid_ff       <= 1'b0;
         pop_ff             <= 1'b0;
      end else begin
         pool_base_ff       <= pool_base_in;
         pool_top_ff        <= pool_top_in;
         freed_count_ff     <= freed_count_in;
         untouched_count_ff <= untouched_count_in;
         untouched_base_ff  <= untouched_base_in;
         rsp_valid_ff       <= rsp_valid_in;
         pop_ff             <= pop_in;
      end
      granted_ff    <= granted_in;
      status_ff     <= status_in;
      free_pages_ff <= free_pages_in;
   end

   // popped page comes straight from the RAM output register
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_granted_address = pop_ff ? {mem_rd_data, {PAGE_SHIFT{1'b0}}} : granted_ff;
   assign rsp_status          = status_ff;
   assign rsp_free_pages      = free_pages_ff;

   a_rsp_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("no result strobe after accepted command");

   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      !accept |=> !rsp_valid)
      else $error("result strobe without accepted command");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      total <= (CNT_W + 1)'(MAX_PAGES))
      else $error("free page count exceeds store size");

   a_empty_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_EMPTY) |->
         (rsp_granted_address == '0 && rsp_free_pages == '0 && !pop_ff))
      else $error("empty alloc with nonzero address or count");

endmodule

// ===== tb/sv/tb_page_free_list_allocator.sv =====
// Self-checking testbench for page_free_list_allocator: directed and random
// alloc/free/init traffic, checked against a LIFO free-page predictor.
// Depends on pfla_pkg and the page_free_list_allocator RTL.
module tb_page_free_list_allocator;
   import pfla_pkg::*;

   localparam int AW         = PFLA_ADDR_BITS;
   localparam int PAGE_SHIFT = $clog2(PFLA_PAGE_BYTES);
   localparam int PAGE_NUM_W = AW - PAGE_SHIFT;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam logic [AW-1:0]    ADDR_ONES  = '1;

   typedef longint unsigned u64_type;

   typedef struct packed {
      logic [AW-1:0]       granted;
      logic [STATUS_W-1:0] status;
      logic [FREE_W-1:0]   free_pages;
   } alloc_result_type;

   function automatic logic [AW-1:0] page_to_addr(u64_type page);
      return AW'(page * PFLA_PAGE_BYTES);
   endfunction

   class alloc_scoreboard_type;
      logic [AW-1:0]         pool_base;
      logic [AW-1:0]         pool_top;
      logic [PAGE_NUM_W-1:0] freed_pages [PFLA_MAX_PAGES];
      int unsigned           freed_cnt;
      int unsigned           untouched_cnt;
      u64_type               untouched_first;
      alloc_result_type      pending_results [$];
      logic [AW-1:0]         loaned_pages [$];   // granted pages to give back (may hold already freed ones)
      int unsigned           errors;
      int unsigned           checked;
      int unsigned           pools;
      int unsigned           cmd_seen [4];
      int unsigned           status_seen [4];

      function new();
         pool_base = '0;
         pool_top = '0;
         freed_cnt = 0;
         untouched_cnt = 0;
         untouched_first = 0;
         errors = 0;
         checked = 0;
         pools = 1;
         foreach (cmd_seen[i]) cmd_seen[i] = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [AW-1:0] value);
         if (idx == CSR_POOL_BASE) begin
            pool_base = value;
         end else begin
            pool_top = value;
         end
         loaned_pages.delete();
      endfunction

      // Predict the result of one accepted command and update the pool.
      function void accept_command(logic [CMD_W-1:0] cmd, logic [AW-1:0] addr);
         alloc_result_type r;
         u64_type b, t, first, last, n;
         r.granted = '0;
         r.status = ST_OK;
         cmd_seen[cmd]++;
         case (cmd)
            CMD_ALLOC: begin
               if (freed_cnt > 0) begin
                  freed_cnt--;
                  r.granted = page_to_addr(freed_pages[freed_cnt]);
               end else if (untouched_cnt > 0) begin
                  untouched_cnt--;
                  r.granted = page_to_addr(untouched_first + untouched_cnt);
               end else begin
                  r.status = ST_EMPTY;
               end
               if (r.status == ST_OK) loaned_pages.push_back(r.granted);
            end
            CMD_FREE: begin
               if (addr % PFLA_PAGE_BYTES != 0 || addr < pool_base || addr >= pool_top) begin
                  r.status = ST_BAD;
               end else if (freed_cnt + untouched_cnt >= PFLA_MAX_PAGES) begin
                  r.status = ST_FULL;
               end else begin
                  freed_pages[freed_cnt] = PAGE_NUM_W'(addr >> PAGE_SHIFT);
                  freed_cnt++;
               end
            end
            CMD_INIT: begin
               b = pool_base;
               t = pool_top;
               first = (b + PFLA_PAGE_BYTES - 1) / PFLA_PAGE_BYTES;
               last = t / PFLA_PAGE_BYTES;
               n = (last > first) ? last - first : 0;
               if (n > PFLA_MAX_PAGES) begin
                  n = PFLA_MAX_PAGES;
                  r.status = ST_FULL;
               end
               freed_cnt = 0;
               untouched_cnt = 32'(n);
               untouched_first = first;
            end
            default: ;
         endcase
         r.free_pages = FREE_W'(freed_cnt + untouched_cnt);
         status_seen[r.status]++;
         pending_results.push_back(r);
      endfunction

      function void check_result(alloc_result_type got);
         alloc_result_type want;
         if (pending_results.size() == 0) begin
            $error("result with no command pending: %p", got);
            errors++;
            return;
         end
         want = pending_results.pop_front();
         checked++;
         if (got.granted !== want.granted) begin
            $error("granted_address: expected %h, got %h", want.granted, got.granted);
            errors++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
         end
         if (got.free_pages !== want.free_pages) begin
            $error("free_pages: expected %0d, got %0d", want.free_pages, got.free_pages);
            errors++;
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [CMD_W-1:0]     req_command;
   logic [AW-1:0]        req_page_address;
   logic                 rsp_valid;
   logic [AW-1:0]        rsp_granted_address;
   logic [STATUS_W-1:0]  rsp_status;
   logic [FREE_W-1:0]    rsp_free_pages;
   logic                 csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [AW-1:0]        csr_write_data;

   alloc_scoreboard_type sb = new();

   page_free_list_allocator dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_command         (req_command),
      .req_page_address    (req_page_address),
      .rsp_valid           (rsp_valid),
      .rsp_granted_address (rsp_granted_address),
      .rsp_status          (rsp_status),
      .rsp_free_pages      (rsp_free_pages),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // result of the previous transfer is checked before the new one is noted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid)
            sb.check_result(alloc_result_type'{rsp_granted_address, rsp_status,
                                               rsp_free_pages});
         if (start && !busy)
            sb.accept_command(req_command, req_page_address);
      end
   end

   function automatic logic [AW-1:0] rand_addr();
      logic [AW-33:0] hi;
      hi = (AW-32)'($urandom);
      return {hi, 32'($urandom)};
   endfunction

   // Free address that fails the checks: unaligned, below base, or at/above top.
   function automatic logic [AW-1:0] bad_address();
      u64_type b, t, r;
      b = sb.pool_base;
      t = sb.pool_top;
      r = {$urandom, $urandom};
      case ($urandom_range(0, 2))
         0: return AW'(((b + PFLA_PAGE_BYTES - 1) / PFLA_PAGE_BYTES) * PFLA_PAGE_BYTES
                       + $urandom_range(1, PFLA_PAGE_BYTES - 1));
         1: if (b != 0) return AW'((r % b) / PFLA_PAGE_BYTES * PFLA_PAGE_BYTES);
         default: ;
      endcase
      return AW'(((t + PFLA_PAGE_BYTES - 1) / PFLA_PAGE_BYTES + $urandom_range(0, 3))
                 * PFLA_PAGE_BYTES);
   endfunction

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send(input logic [CMD_W-1:0] cmd, input logic [AW-1:0] addr);
      start = 1'b1;
      req_command = cmd;
      req_page_address = addr;
      do @(posedge clock); while (busy !== 1'b0);
      @(negedge clock);
   endtask

   task automatic maybe_idle(input bit enabled);
      if (enabled && $urandom_range(0, 3) == 0) begin
         start = 1'b0;
         req_command = CMD_W'($urandom);
         req_page_address = rand_addr();
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
   endtask

   task automatic drain();
      start = 1'b0;
      for (int w = 0; w < 200 && sb.pending_results.size() != 0; w++) @(negedge clock);
      if (sb.pending_results.size() != 0) begin
         $error("%0d results never arrived", sb.pending_results.size());
         sb.errors++;
         sb.pending_results.delete();
      end
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [AW-1:0] value);
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_write_data = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
      sb.set_register(idx, value);
   endtask

   task automatic set_pool(input logic [AW-1:0] base, input logic [AW-1:0] top);
      drain();
      write_csr(CSR_POOL_BASE, base);
      write_csr(CSR_POOL_TOP, top);
      sb.pools++;
   endtask

   task automatic random_pool(input int max_pages);
      u64_type b, t;
      b = ($urandom_range(0, 1) == 0) ? u64_type'(rand_addr()) : $urandom_range(0, 1 << 20);
      t = ((b + PFLA_PAGE_BYTES - 1) / PFLA_PAGE_BYTES + $urandom_range(0, max_pages))
          * PFLA_PAGE_BYTES + $urandom_range(0, PFLA_PAGE_BYTES - 1);
      if (t > ADDR_ONES) t = ADDR_ONES;
      set_pool(AW'(b), AW'(t));
   endtask

   // Mostly alloc / give-back traffic on the current pool, plus bad frees,
   // stray addresses, re-inits and the unused code.
   task automatic random_phase(input int n_items, input bit idle_on);
      logic [CMD_W-1:0] cmd;
      logic [AW-1:0]    addr;
      u64_type          first, last;
      int               pick, idx;
      send(CMD_INIT, rand_addr());
      for (int i = 1; i < n_items; i++) begin
         maybe_idle(idle_on);
         first = (u64_type'(sb.pool_base) + PFLA_PAGE_BYTES - 1) / PFLA_PAGE_BYTES;
         last = u64_type'(sb.pool_top) / PFLA_PAGE_BYTES;
         pick = $urandom_range(0, 99);
         cmd = CMD_ALLOC;
         addr = rand_addr();
         if (pick < 42) begin
         end else if (pick < 75) begin
            if (sb.loaned_pages.size() != 0) begin
               idx = $urandom_range(0, sb.loaned_pages.size() - 1);
               cmd = CMD_FREE;
               addr = sb.loaned_pages[idx];
               // sometimes keep it on the list so it gets freed twice
               if ($urandom_range(0, 4) != 0) sb.loaned_pages.delete(idx);
            end
         end else if (pick < 83) begin
            cmd = CMD_FREE;
            addr = bad_address();
         end else if (pick < 88) begin
            cmd = CMD_FREE;
         end else if (pick < 92) begin
            if (last > first) begin
               cmd = CMD_FREE;
               addr = page_to_addr(first + $urandom_range(0, int'(last - first - 1)));
            end
         end else if (pick < 95) begin
            cmd = CMD_INIT;
         end else if (pick < 98) begin
            cmd = CMD_UNUSED;
         end
         send(cmd, addr);
      end
   endtask

   initial begin
      #10_000_000;
      $display("page_free_list_allocator test failed");
      $finish;
   end

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_command = CMD_ALLOC;
      req_page_address = '0;
      csr_write_enable = 1'b0;
      csr_index = CSR_POOL_BASE;
      csr_write_data = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty pool straight out of reset
      send(CMD_ALLOC, ADDR_ONES);
      send(CMD_FREE, '0);
      send(CMD_INIT, '0);
      send(CMD_UNUSED, '0);

      // whole address space: pool clipped to MAX_PAGES
      set_pool('0, ADDR_ONES);
      send(CMD_INIT, '0);
      send(CMD_FREE, '0);
      send(CMD_ALLOC, '0);
      send(CMD_ALLOC, ADDR_ONES);
      send(CMD_FREE, page_to_addr(PFLA_MAX_PAGES - 1));
      send(CMD_FREE, page_to_addr(PFLA_MAX_PAGES - 1));
      send(CMD_FREE, ADDR_ONES & ~AW'(PFLA_PAGE_BYTES - 1));
      send(CMD_ALLOC, '0);
      send(CMD_FREE, ADDR_ONES);
      send(CMD_FREE, ADDR_ONES & ~AW'(PFLA_PAGE_BYTES - 1));
      send(CMD_ALLOC, '0);
      send(CMD_FREE, AW'(PFLA_PAGE_BYTES - 1));
      send(CMD_UNUSED, ADDR_ONES);
      random_phase(120, 1'b1);

      // inverted pool
      set_pool(ADDR_ONES, '0);
      send(CMD_INIT, ADDR_ONES);
      send(CMD_ALLOC, '0);
      send(CMD_FREE, ADDR_ONES & ~AW'(PFLA_PAGE_BYTES - 1));
      random_phase(40, 1'b1);

      // exactly MAX_PAGES pages above a nonzero base
      set_pool(AW'(5 * PFLA_PAGE_BYTES), AW'((5 + PFLA_MAX_PAGES) * PFLA_PAGE_BYTES));
      send(CMD_INIT, '0);
      send(CMD_FREE, AW'(PFLA_PAGE_BYTES));
      send(CMD_FREE, AW'((5 + PFLA_MAX_PAGES) * PFLA_PAGE_BYTES));
      send(CMD_FREE, AW'(5 * PFLA_PAGE_BYTES));
      random_phase(100, 1'b1);

      for (int p = 0; p < 6; p++) begin
         random_pool(p == 2 ? 3000 : 40);
         random_phase(130, p < 4);
      end
      drain();

      $display("Ran %0d commands (alloc %0d, free %0d, init %0d, unused %0d) over %0d pools",
               sb.checked, sb.cmd_seen[CMD_ALLOC], sb.cmd_seen[CMD_FREE],
               sb.cmd_seen[CMD_INIT], sb.cmd_seen[CMD_UNUSED], sb.pools);
      $display("Expected statuses: ok %0d, no free page %0d, bad free %0d, full %0d",
               sb.status_seen[ST_OK], sb.status_seen[ST_EMPTY],
               sb.status_seen[ST_BAD], sb.status_seen[ST_FULL]);
      if (sb.errors == 0) begin
         $display("page_free_list_allocator test passed");
      end else begin
         $display("page_free_list_allocator test failed");
      end
      $finish;
   end

endmodule
